/* rtl/msd_pkg.sv */
// msd_pkg: shared types and constants for the multi-switch debouncer
// no dependencies; imported by msd_update, msd_emit and the top level

package msd_pkg;

	// width of the settle count register and of each channel counter
	localparam int unsigned CntW = 4;

	typedef logic [CntW-1:0] cnt_t;

	// settle count after reset, in ticks
	localparam cnt_t SETTLE_RESET = cnt_t'(5);

endpackage

/* rtl/msd_update.sv */
// msd_update: per-channel debounce state and the change mask of one tick
// depends on msd_pkg

module msd_update import msd_pkg::*; #(
	parameter int unsigned NUM_SWITCHES = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cnt_t                    settle_q,
	input  logic                    tick,
	input  logic [NUM_SWITCHES-1:0] level,
	output logic                    batch_load,
	output logic                    batch_first,
	output logic [NUM_SWITCHES-1:0] batch_base,
	output logic [NUM_SWITCHES-1:0] batch_mask
);

	logic                    started_q;
	logic [NUM_SWITCHES-1:0] stable_q;
	logic [NUM_SWITCHES-1:0] sampled_q;
	cnt_t                    cnt_q [NUM_SWITCHES];

	logic [NUM_SWITCHES-1:0] diff;
	logic [NUM_SWITCHES-1:0] climb;
	logic [NUM_SWITCHES-1:0] upd;
	cnt_t                    cnt_d [NUM_SWITCHES];

	// per-channel decision, channels are independent of each other
	always_comb begin
		for (int i = 0; i < NUM_SWITCHES; i++) begin
			diff[i]  = level[i] != sampled_q[i];
			climb[i] = !diff[i] && (cnt_q[i] < settle_q);
			upd[i]   = !diff[i] && !climb[i] && (sampled_q[i] != stable_q[i]);
			if (diff[i]) begin
				cnt_d[i] = '0;
			end else if (climb[i]) begin
				cnt_d[i] = cnt_q[i] + cnt_t'(1);
			end else begin
				cnt_d[i] = cnt_q[i];
			end
		end
	end

	// state registers, updated once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			stable_q  <= '0;
			sampled_q <= '0;
			for (int i = 0; i < NUM_SWITCHES; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (tick) begin
			if (!started_q) begin
				started_q <= 1'b1;
				stable_q  <= level;
				sampled_q <= level;
			end else begin
				stable_q  <= stable_q ^ upd;
				sampled_q <= sampled_q ^ diff;
				for (int i = 0; i < NUM_SWITCHES; i++) begin
					cnt_q[i] <= cnt_d[i];
				end
			end
		end
	end

	// batch handed to the report stage
	assign batch_first = !started_q;
	assign batch_base  = started_q ? stable_q : level;
	assign batch_mask  = started_q ? upd : '0;
	assign batch_load  = tick && (!started_q || (|upd));

endmodule

/* rtl/msd_emit.sv */
// msd_emit: batch register and output register, one report per beat
// depends on msd_pkg

module msd_emit import msd_pkg::*; #(
	parameter int unsigned NUM_SWITCHES = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    batch_load,
	input  logic                    batch_first,
	input  logic [NUM_SWITCHES-1:0] batch_base,
	input  logic [NUM_SWITCHES-1:0] batch_mask,
	output logic                    batch_busy,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [NUM_SWITCHES-1:0] report_bits,
	output logic                    last_report
);

	logic                    valid_s1;
	logic                    first_s1;
	logic [NUM_SWITCHES-1:0] base_s1;
	logic [NUM_SWITCHES-1:0] pend_s1;

	logic                    out_valid_q;
	logic [NUM_SWITCHES-1:0] report_q;
	logic                    last_q;

	logic [NUM_SWITCHES-1:0] lowest;
	logic [NUM_SWITCHES-1:0] next_report;
	logic                    single;
	logic                    out_free;
	logic                    move;

	// lowest pending channel gives the next report
	always_comb begin
		lowest      = pend_s1 & (~pend_s1 + NUM_SWITCHES'(1));
		next_report = first_s1 ? base_s1 : (base_s1 ^ lowest);
		single      = first_s1 || ((pend_s1 & (pend_s1 - NUM_SWITCHES'(1))) == '0);
		out_free    = !out_valid_q || !out_stall;
		move        = valid_s1 && out_free;
		batch_busy  = valid_s1 && !(move && single);
	end

	// batch register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (batch_load) begin
			valid_s1 <= 1'b1;
		end else if (move && single) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (batch_load) begin
			first_s1 <= batch_first;
			base_s1  <= batch_base;
			pend_s1  <= batch_mask;
		end else if (move) begin
			base_s1 <= next_report;
			pend_s1 <= pend_s1 & ~lowest;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			report_q <= next_report;
			last_q   <= single;
		end
	end

	assign out_valid   = out_valid_q;
	assign report_bits = report_q;
	assign last_report = last_q;

endmodule

/* rtl/multi_switch_debouncer_unit.sv */
// multi_switch_debouncer_unit: top level of the multi-switch debouncer
// depends on msd_pkg, msd_update and msd_emit

// Each input beat is one sampling tick of NUM_SWITCHES switch levels. The
// debounce state is updated in the cycle the tick is taken, and the channels
// whose stable level changes are queued as one batch that the output register
// sends one report per cycle while out_stall is low, lowest channel first,
// with last_report on the final one. A tick that changes no stable bit gives
// no report. Ticks are taken one per cycle while each causes at most one
// report and out_stall is low; a tick with more than one report keeps the batch
// register busy, stalling the next tick, until its last report moves to the
// output register. The very first tick after reset gives one report of its
// levels. settle_count is written through the cfg channel, which is always
// ready, and should only be written while no reports are pending.

module multi_switch_debouncer_unit import msd_pkg::*; #(
	parameter int unsigned NUM_SWITCHES = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  cnt_t                    settle_count,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [NUM_SWITCHES-1:0] switch_bits,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [NUM_SWITCHES-1:0] report_bits,
	output logic                    last_report
);

	cnt_t                    settle_q;
	logic                    tick;
	logic                    batch_load;
	logic                    batch_first;
	logic [NUM_SWITCHES-1:0] batch_base;
	logic [NUM_SWITCHES-1:0] batch_mask;
	logic                    batch_busy;

	// settle count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			settle_q <= settle_count;
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = batch_busy;
	assign tick      = in_valid && !in_stall;

	msd_update #(
		.NUM_SWITCHES(NUM_SWITCHES)
	) u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.settle_q   (settle_q),
		.tick       (tick),
		.level      (switch_bits),
		.batch_load (batch_load),
		.batch_first(batch_first),
		.batch_base (batch_base),
		.batch_mask (batch_mask)
	);

	msd_emit #(
		.NUM_SWITCHES(NUM_SWITCHES)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.batch_load (batch_load),
		.batch_first(batch_first),
		.batch_base (batch_base),
		.batch_mask (batch_mask),
		.batch_busy (batch_busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.report_bits(report_bits),
		.last_report(last_report)
	);

endmodule

/* rtl/msd_checker.sv */
// msd_checker: port-level checks of the multi-switch debouncer
// no package needed; bound to multi_switch_debouncer_unit below

module msd_checker #(
	parameter int unsigned NUM_SWITCHES = 4
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic [NUM_SWITCHES-1:0] switch_bits,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [NUM_SWITCHES-1:0] report_bits,
	input logic                    last_report
);

	// a stalled tick beat stays valid and keeps its levels
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(switch_bits))
		else $error("tick beat changed while stalled");

	// a stalled beat stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a stalled beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(report_bits) && $stable(last_report))
		else $error("report payload changed while stalled");

	// the rest of a batch follows a taken non-final report in the next cycle
	a_batch_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_report |=> out_valid)
		else $error("report batch broken off before its last beat");

	// no new tick while a stalled batch still has reports to send
	a_tick_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && !last_report |-> in_stall)
		else $error("tick taken while a batch is pending");

endmodule

bind multi_switch_debouncer_unit msd_checker #(
	.NUM_SWITCHES(NUM_SWITCHES)
) u_msd_checker (.*);
